>>> src/dwpd_pkg.sv
// Package with the shared types and constants of the dual-wheel PID drive.
`timescale 1ns / 1ps

package dwpd_pkg;

   localparam logic signed [16:0] SETTLE_BAND  = 17'sd5;
   localparam logic [15:0]        SETTLE_MS    = 16'd50;
   localparam logic [7:0]         CROSS_NUM    = 8'd245;
   localparam logic [6:0]         CROSS_DEN    = 7'd100;
   localparam logic [12:0]        CROSS_RECIP  = 13'd5243;
   localparam logic [25:0]        CROSS_SAT    = 26'd12800;
   localparam logic [6:0]         OUT_LIMIT    = 7'd127;
   localparam logic signed [63:0] ITERM_LIMIT  = 64'sh1000_0000_0000_0000;
   localparam logic [61:0]        Q28_ROUND    = 62'h0FFF_FFFF;

   typedef enum logic [2:0] {
      REG_TARGET  = 3'd0,
      REG_GAIN_P  = 3'd1,
      REG_GAIN_I  = 3'd2,
      REG_GAIN_D  = 3'd3,
      REG_MAX     = 3'd4,
      REG_MIN     = 3'd5,
      REG_REVERSE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } pipe_en_type;

   typedef struct packed {
      logic signed [16:0] err_r;
      logic signed [16:0] err_l;
      logic signed [31:0] sum_r;
      logic signed [31:0] sum_l;
      logic signed [17:0] derr_r;
      logic signed [17:0] derr_l;
      logic signed [16:0] diff;
      logic               done;
   } stage1_type;

endpackage

>>> src/dwpd_if.sv
// Valid/ready channel interfaces for samples and drive results.
`timescale 1ns / 1ps

interface dwpd_req_if;
   logic               valid;
   logic               ready;
   logic               start_req;
   logic signed [15:0] right_count;
   logic signed [15:0] left_count;
   logic [7:0]         elapsed_ms;

   modport source (output valid, start_req, right_count, left_count, elapsed_ms, input ready);
   modport sink (input valid, start_req, right_count, left_count, elapsed_ms, output ready);
endinterface

interface dwpd_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] left_out;
   logic signed [7:0] right_out;
   logic              settled;

   modport source (output valid, left_out, right_out, settled, input ready);
   modport sink (input valid, left_out, right_out, settled, output ready);
endinterface

>>> src/dwpd_state.sv
// Front stage: wheel errors, deltas and difference, saturating integrals, settle timer and done flag.
`timescale 1ns / 1ps

module dwpd_state (
   input  logic                 clock,
   input  logic                 reset,
   input  dwpd_pkg::pipe_en_type en,
   input  logic                 accept,
   input  logic                 start_req,
   input  logic signed [15:0]   right_count,
   input  logic signed [15:0]   left_count,
   input  logic [7:0]           elapsed_ms,
   input  logic [14:0]          target_count,
   output dwpd_pkg::stage1_type s1_ff
);
   import dwpd_pkg::*;

   logic signed [31:0] rsum_ff, rsum_in, lsum_ff, lsum_in;
   logic signed [16:0] rprev_ff, rprev_in, lprev_ff, lprev_in;
   logic [15:0]        timer_ff, timer_in;
   logic               done_ff, done_in;
   stage1_type         s1_in;

   logic signed [31:0] rsum_cur, lsum_cur, rsum_new, lsum_new;
   logic signed [16:0] rprev_cur, lprev_cur;
   logic [15:0]        timer_cur, timer_new;
   logic               done_cur;
   logic signed [16:0] rcx, lcx, ra, la, re, le;
   logic [16:0]        tsum;
   logic               out_band;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] s,
                                                  input logic signed [16:0] e);
      logic signed [32:0] t;
      begin
         t = {s[31], s} + {{16{e[16]}}, e};
         if (t[32] != t[31]) begin
            sat_add = t[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            sat_add = t[31:0];
         end
      end
   endfunction

   always_comb begin
      rsum_cur  = start_req ? '0 : rsum_ff;
      lsum_cur  = start_req ? '0 : lsum_ff;
      rprev_cur = start_req ? '0 : rprev_ff;
      lprev_cur = start_req ? '0 : lprev_ff;
      timer_cur = start_req ? '0 : timer_ff;
      done_cur  = start_req ? 1'b0 : done_ff;

      rcx = {right_count[15], right_count};
      lcx = {left_count[15], left_count};
      ra  = right_count[15] ? -rcx : rcx;
      la  = left_count[15] ? -lcx : lcx;
      re  = $signed({2'b00, target_count}) - ra;
      le  = $signed({2'b00, target_count}) - la;

      rsum_new = sat_add(rsum_cur, re);
      lsum_new = sat_add(lsum_cur, le);

      tsum      = {1'b0, timer_cur} + {9'b0, elapsed_ms};
      timer_new = tsum[16] ? 16'hFFFF : tsum[15:0];
      out_band  = (re > SETTLE_BAND) || (re < -SETTLE_BAND) ||
                  (le > SETTLE_BAND) || (le < -SETTLE_BAND);
      if (out_band) begin
         timer_new = '0;
      end

      if (done_cur) begin
         rsum_in  = rsum_cur;
         lsum_in  = lsum_cur;
         rprev_in = rprev_cur;
         lprev_in = lprev_cur;
         timer_in = timer_cur;
         done_in  = done_cur;
      end else begin
         rsum_in  = rsum_new;
         lsum_in  = lsum_new;
         rprev_in = re;
         lprev_in = le;
         timer_in = timer_new;
         done_in  = timer_new > SETTLE_MS;
      end

      s1_in.err_r  = re;
      s1_in.err_l  = le;
      s1_in.sum_r  = rsum_new;
      s1_in.sum_l  = lsum_new;
      s1_in.derr_r = {re[16], re} - {rprev_cur[16], rprev_cur};
      s1_in.derr_l = {le[16], le} - {lprev_cur[16], lprev_cur};
      s1_in.diff   = la - ra;
      s1_in.done   = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsum_ff  <= '0;
         lsum_ff  <= '0;
         rprev_ff <= '0;
         lprev_ff <= '0;
         timer_ff <= '0;
         done_ff  <= 1'b0;
      end else if (accept) begin
         rsum_ff  <= rsum_in;
         lsum_ff  <= lsum_in;
         rprev_ff <= rprev_in;
         lprev_ff <= lprev_in;
         timer_ff <= timer_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         s1_ff <= s1_in;
      end
   end

endmodule

>>> src/dwpd_lane.sv
// One wheel's PID lane: gain products, term sum, scaling and drive clamping.
`timescale 1ns / 1ps

module dwpd_lane (
   input  logic                  clock,
   input  dwpd_pkg::pipe_en_type en,
   input  logic [31:0]           gain_p,
   input  logic [31:0]           gain_i,
   input  logic [31:0]           gain_d,
   input  logic [6:0]            max_drive,
   input  logic [6:0]            min_drive,
   input  logic signed [16:0]    err,
   input  logic signed [31:0]    sum,
   input  logic signed [17:0]    derr,
   output logic signed [7:0]     drive_ff
);
   import dwpd_pkg::*;

   logic signed [49:0] p_ff, p_in;
   logic signed [50:0] d_ff, d_in;
   logic signed [64:0] i_prod;
   logic signed [63:0] i_ff, i_clamp;
   logic signed [61:0] s_ff, s_in, s_bias;
   logic signed [33:0] q, mx, mn;
   logic signed [7:0]  drive_in;

   always_comb begin
      p_in   = $signed({1'b0, gain_p}) * err;
      d_in   = $signed({1'b0, gain_d}) * derr;
      i_prod = $signed({1'b0, gain_i}) * sum;

      if (i_ff > ITERM_LIMIT) begin
         i_clamp = ITERM_LIMIT;
      end else if (i_ff < -ITERM_LIMIT) begin
         i_clamp = -ITERM_LIMIT;
      end else begin
         i_clamp = i_ff;
      end
      s_in = $signed(i_clamp[61:0]) + {{12{p_ff[49]}}, p_ff} + {{11{d_ff[50]}}, d_ff};

      s_bias = s_ff + (s_ff[61] ? $signed(Q28_ROUND) : 62'sd0);
      q      = s_bias[61:28];
      mx     = $signed({27'b0, max_drive});
      mn     = $signed({27'b0, min_drive});
      if (q > mx) begin
         q = mx;
      end else if (q < -mx) begin
         q = -mx;
      end
      if (q > 34'sd0 && q < mn) begin
         q = mn;
      end else if (q < 34'sd0 && q > -mn) begin
         q = -mn;
      end
      drive_in = q[7:0];
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         p_ff <= p_in;
         d_ff <= d_in;
         i_ff <= i_prod[63:0];
      end
      if (en.s3) begin
         s_ff <= s_in;
      end
      if (en.s4) begin
         drive_ff <= drive_in;
      end
   end

endmodule

>>> src/dwpd_merge.sv
// Merging stage: cross correction of the right drive, direction and settle zeroing.
`timescale 1ns / 1ps

module dwpd_merge (
   input  logic                  clock,
   input  dwpd_pkg::pipe_en_type en,
   input  logic [1:0]            reverse_bits,
   input  logic signed [16:0]    diff,
   input  logic                  done,
   input  logic signed [7:0]     left_drive,
   input  logic signed [7:0]     right_drive,
   output logic signed [7:0]     left_out_ff,
   output logic signed [7:0]     right_out_ff,
   output logic                  settled_ff
);
   import dwpd_pkg::*;

   logic signed [24:0] k2_ff, k3_ff, k4_ff, k_in;
   logic               done2_ff, done3_ff, done4_ff, done5_ff;
   logic signed [25:0] x_ff, x_in;
   logic signed [7:0]  left5_ff;
   logic [25:0]        mag;
   logic [26:0]        prod;
   logic [6:0]         qmag;
   logic signed [7:0]  right_in, left_in;

   always_comb begin
      k_in = diff * $signed({1'b0, CROSS_NUM});
      x_in = $signed({1'b0, CROSS_DEN}) * right_drive + $signed({k4_ff[24], k4_ff});

      mag  = x_ff[25] ? -x_ff : x_ff;
      prod = mag[13:0] * CROSS_RECIP;
      if (mag >= CROSS_SAT) begin
         qmag = OUT_LIMIT;
      end else begin
         qmag = prod[25:19];
      end
      right_in = x_ff[25] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      left_in  = left5_ff;
      if (reverse_bits[0]) begin
         right_in = -right_in;
      end
      if (reverse_bits[1]) begin
         left_in = -left_in;
      end
      if (done5_ff) begin
         right_in = '0;
         left_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         k2_ff    <= k_in;
         done2_ff <= done;
      end
      if (en.s3) begin
         k3_ff    <= k2_ff;
         done3_ff <= done2_ff;
      end
      if (en.s4) begin
         k4_ff    <= k3_ff;
         done4_ff <= done3_ff;
      end
      if (en.s5) begin
         x_ff     <= x_in;
         left5_ff <= left_drive;
         done5_ff <= done4_ff;
      end
      if (en.s6) begin
         left_out_ff  <= left_in;
         right_out_ff <= right_in;
         settled_ff   <= done5_ff;
      end
   end

endmodule

>>> src/dual_wheel_pid_drive.sv
// Path: a sample accepted into stage 1 moves on through stages 2 to 6 and is offered on rsp_ch from stage 6.
// Throughput: one sample per cycle while rsp_ch is ready, through a six-stage pipeline with a lane per wheel.
// Integrals, previous errors, timer and done flag update at the acceptance edge itself.
// Each stage holds only while the stage after it is full and stalled.
// Reset (synchronous): pipeline empties, run state clears, registers take defaults.
`timescale 1ns / 1ps

module dual_wheel_pid_drive (
   input  logic        clock,
   input  logic        reset,
   dwpd_req_if.sink    req_ch,
   dwpd_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dwpd_pkg::*;

   logic [14:0]   target_ff;
   logic [31:0]   gain_p_ff, gain_i_ff, gain_d_ff;
   logic [6:0]    max_ff, min_ff;
   logic [1:0]    reverse_ff;
   logic [6:1]    valid_ff;
   logic [6:1]    rdy;
   pipe_en_type   en;
   stage1_type    s1;
   csr_index_type csr_index;
   logic          csr_write;
   logic          accept;
   logic signed [7:0] drive_r, drive_l;

   assign csr_index  = csr_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         REG_TARGET:  csr_prdata = {17'b0, target_ff};
         REG_GAIN_P:  csr_prdata = gain_p_ff;
         REG_GAIN_I:  csr_prdata = gain_i_ff;
         REG_GAIN_D:  csr_prdata = gain_d_ff;
         REG_MAX:     csr_prdata = {25'b0, max_ff};
         REG_MIN:     csr_prdata = {25'b0, min_ff};
         REG_REVERSE: csr_prdata = {30'b0, reverse_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         gain_p_ff  <= '0;
         gain_i_ff  <= '0;
         gain_d_ff  <= '0;
         max_ff     <= OUT_LIMIT;
         min_ff     <= '0;
         reverse_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_TARGET:  target_ff  <= csr_pwdata[14:0];
            REG_GAIN_P:  gain_p_ff  <= csr_pwdata;
            REG_GAIN_I:  gain_i_ff  <= csr_pwdata;
            REG_GAIN_D:  gain_d_ff  <= csr_pwdata;
            REG_MAX:     max_ff     <= csr_pwdata[6:0];
            REG_MIN:     min_ff     <= csr_pwdata[6:0];
            REG_REVERSE: reverse_ff <= csr_pwdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rdy[6] = !valid_ff[6] || rsp_ch.ready;
      for (int k = 5; k >= 1; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      en.s1 = rdy[1];
      en.s2 = rdy[2];
      en.s3 = rdy[3];
      en.s4 = rdy[4];
      en.s5 = rdy[5];
      en.s6 = rdy[6];
   end

   assign req_ch.ready = rdy[1];
   assign accept       = req_ch.valid && rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[1]) begin
            valid_ff[1] <= req_ch.valid;
         end
         for (int k = 2; k <= 6; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   dwpd_state u_state (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .accept       (accept),
      .start_req    (req_ch.start_req),
      .right_count  (req_ch.right_count),
      .left_count   (req_ch.left_count),
      .elapsed_ms   (req_ch.elapsed_ms),
      .target_count (target_ff),
      .s1_ff        (s1)
   );

   dwpd_lane u_lane_r (
      .clock     (clock),
      .en        (en),
      .gain_p    (gain_p_ff),
      .gain_i    (gain_i_ff),
      .gain_d    (gain_d_ff),
      .max_drive (max_ff),
      .min_drive (min_ff),
      .err       (s1.err_r),
      .sum       (s1.sum_r),
      .derr      (s1.derr_r),
      .drive_ff  (drive_r)
   );

   dwpd_lane u_lane_l (
      .clock     (clock),
      .en        (en),
      .gain_p    (gain_p_ff),
      .gain_i    (gain_i_ff),
      .gain_d    (gain_d_ff),
      .max_drive (max_ff),
      .min_drive (min_ff),
      .err       (s1.err_l),
      .sum       (s1.sum_l),
      .derr      (s1.derr_l),
      .drive_ff  (drive_l)
   );

   dwpd_merge u_merge (
      .clock        (clock),
      .en           (en),
      .reverse_bits (reverse_ff),
      .diff         (s1.diff),
      .done         (s1.done),
      .left_drive   (drive_l),
      .right_drive  (drive_r),
      .left_out_ff  (rsp_ch.left_out),
      .right_out_ff (rsp_ch.right_out),
      .settled_ff   (rsp_ch.settled)
   );

   assign rsp_ch.valid = valid_ff[6];

endmodule

>>> src/dwpd_checker.sv
// Port-level checker for the dual-wheel PID drive, with its bind statement.
`timescale 1ns / 1ps

module dwpd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [7:0] left_out,
   input logic signed [7:0] right_out,
   input logic              settled
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("A stalled result was withdrawn before its transfer.");

   a_settled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && settled |-> left_out == 8'sd0 && right_out == 8'sd0)
      else $error("A settled result carries a nonzero drive.");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> left_out != 8'sh80 && right_out != 8'sh80)
      else $error("A drive lies outside the symmetric range.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result is offered straight after reset.");

endmodule

bind dual_wheel_pid_drive dwpd_checker u_dwpd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .left_out  (rsp_ch.left_out),
   .right_out (rsp_ch.right_out),
   .settled   (rsp_ch.settled)
);
